@@ rtl/trb_pkg.sv @@
`timescale 1ns / 1ps

package trb_pkg;

  localparam int unsigned TsnBits     = 32;
  localparam int unsigned PayloadBits = 16;

  typedef enum logic [1:0] {
    StsDelivered = 2'd0,
    StsBuffered  = 2'd1,
    StsOld       = 2'd2,
    StsBeyond    = 2'd3
  } status_e;

  typedef struct packed {
    logic [TsnBits-1:0]     chunk_tsn;
    logic [PayloadBits-1:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [TsnBits-1:0]     out_tsn;
    logic [PayloadBits-1:0] out_payload;
    logic                   last_of_run;
  } out_item_t;

  // classified chunk handed from the intake side to the reorder engine
  typedef struct packed {
    status_e  kind;
    in_item_t item;
  } cls_t;

endpackage

@@ rtl/trb_ram.sv @@
`timescale 1ns / 1ps

module trb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/trb_fifo.sv @@
`timescale 1ns / 1ps

module trb_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/trb_front.sv @@
`timescale 1ns / 1ps

module trb_front #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  trb_pkg::in_item_t        item_i,
  input  logic [trb_pkg::TsnBits-1:0] due_tsn_i,
  output logic                     cls_valid_o,
  input  logic                     cls_ready_i,
  output trb_pkg::cls_t            cls_o
);
  import trb_pkg::*;

  logic                         q_empty;
  logic [$bits(in_item_t)-1:0]  q_data;
  in_item_t                     head;
  logic [TsnBits-1:0]           tsn_gap;

  trb_fifo #(
    .WIDTH ($bits(in_item_t))
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (item_i),
    .pop_i   (cls_ready_i),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  assign head        = in_item_t'(q_data);
  assign cls_valid_o = !q_empty;

  // serial-number distance from the expected tsn
  assign tsn_gap = head.chunk_tsn - due_tsn_i;

  always_comb begin
    cls_o.item = head;
    priority if (tsn_gap == '0) begin
      cls_o.kind = StsDelivered;
    end else if (tsn_gap[TsnBits-1]) begin
      cls_o.kind = StsOld;
    end else if (tsn_gap > TsnBits'(WINDOW)) begin
      cls_o.kind = StsBeyond;
    end else begin
      cls_o.kind = StsBuffered;
    end
  end

endmodule

@@ rtl/trb_back.sv @@
`timescale 1ns / 1ps

module trb_back #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cls_valid_i,
  output logic                        cls_ready_o,
  input  trb_pkg::cls_t               cls_i,
  output logic [trb_pkg::TsnBits-1:0] due_tsn_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trb_pkg::TsnBits-1:0] cfg_data_i,
  output logic                        empty,
  input  logic                        pop,
  output trb_pkg::out_item_t          result_o
);
  import trb_pkg::*;

  localparam int unsigned IdxW = $clog2(WINDOW);

  typedef enum logic [1:0] {
    StateIdle  = 2'b01,
    StateDrain = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic [TsnBits-1:0]           next_q;
  logic [WINDOW-1:0]            valid_q;
  logic [IdxW-1:0]              head_q, head_nxt;
  logic                         res_full;
  logic                         take, deliver, res_push, cfg_wr;
  out_item_t                    res;
  logic [$bits(out_item_t)-1:0] res_data;
  logic [IdxW-1:0]              off;
  logic [IdxW:0]                phys_sum;
  logic [IdxW-1:0]              phys;
  logic [PayloadBits-1:0]       ram_rdata;
  logic                         ram_we, ram_re;

  assign cls_ready_o = (state_q == StateIdle) && !res_full;
  assign cfg_ready_o = (state_q == StateIdle);
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign take        = cls_valid_i && cls_ready_o;
  assign due_tsn_o   = next_q;

  assign deliver  = (take && cls_i.kind == StsDelivered) ||
                    (state_q == StateDrain && !res_full);
  assign res_push = take || (state_q == StateDrain && !res_full);

  // slot k holds tsn next+1+k, stored at (head + k) mod WINDOW
  assign off      = IdxW'(cls_i.item.chunk_tsn[IdxW-1:0] - next_q[IdxW-1:0] - 1'b1);
  assign phys_sum = {1'b0, head_q} + {1'b0, off};
  assign phys     = (phys_sum >= (IdxW+1)'(WINDOW)) ?
                    IdxW'(phys_sum - (IdxW+1)'(WINDOW)) : phys_sum[IdxW-1:0];
  assign head_nxt = (head_q == IdxW'(WINDOW - 1)) ? '0 : head_q + 1'b1;

  assign ram_we = take && cls_i.kind == StsBuffered;
  // fetch the successor while the current beat goes out
  assign ram_re = deliver && valid_q[0];

  trb_ram #(
    .WIDTH (PayloadBits),
    .DEPTH (WINDOW)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (phys),
    .wdata_i (cls_i.item.payload_handle),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (state_q)
      StateDrain: begin
        res.status      = StsDelivered;
        res.out_tsn     = next_q;
        res.out_payload = ram_rdata;
        res.last_of_run = !valid_q[0];
      end
      default: begin
        res.status      = cls_i.kind;
        res.out_tsn     = cls_i.item.chunk_tsn;
        res.out_payload = (cls_i.kind == StsDelivered) ? cls_i.item.payload_handle : '0;
        res.last_of_run = (cls_i.kind == StsDelivered) ? !valid_q[0] : 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (deliver) begin
      state_d = valid_q[0] ? StateDrain : StateIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
      next_q  <= '0;
      valid_q <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        next_q  <= cfg_data_i;
        valid_q <= '0;
      end else if (deliver) begin
        next_q  <= res.out_tsn + 1'b1;
        valid_q <= valid_q >> 1;
        head_q  <= head_nxt;
      end else if (ram_we) begin
        valid_q[off] <= 1'b1;
      end
    end
  end

  assign res_data = res;

  trb_fifo #(
    .WIDTH ($bits(out_item_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_data),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (result_o)
  );

endmodule

@@ rtl/tsn_reorder_buffer_unit.sv @@
`timescale 1ns / 1ps

// channel   signals                          direction  beat when
// input     push, full, item_i               in         push && !full
// result    empty, pop, result_o             out        pop && !empty
// config    cfg_valid_i, cfg_ready_o,        in         cfg_valid_i && cfg_ready_o
//           cfg_data_i
//
// a chunk that is buffered or dropped, or delivered with no buffered successor, leaves the
// reorder engine idle; an in-order chunk that releases n buffered successors moves it to a
// drain state, one slot read from the window memory per result, that waits on a full result queue
// two-entry queues at intake and at the result side let each side stall independently
// reset expects tsn 0 and empties the window; a config beat restarts the association
module tsn_reorder_buffer_unit #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  trb_pkg::in_item_t           item_i,
  output logic                        empty,
  input  logic                        pop,
  output trb_pkg::out_item_t          result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trb_pkg::TsnBits-1:0] cfg_data_i
);
  import trb_pkg::*;

  logic               cls_valid, cls_ready;
  cls_t               cls;
  logic [TsnBits-1:0] due_tsn;

  trb_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .due_tsn_i   (due_tsn),
    .cls_valid_o (cls_valid),
    .cls_ready_i (cls_ready),
    .cls_o       (cls)
  );

  trb_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_ready_o (cls_ready),
    .cls_i       (cls),
    .due_tsn_o   (due_tsn),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

@@ verif/tsn_reorder_buffer_unit_tb.sv @@
`timescale 1ns / 1ps

module tsn_reorder_buffer_unit_tb;
  import trb_pkg::*;

  localparam int WIN         = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 150;
  localparam int PHASE_ITEMS = 82;

  logic                clk_i;
  logic                rst_ni;
  logic                push = 1'b0;
  logic                full;
  in_item_t            item_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_item_t           result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [TsnBits-1:0]  cfg_data_i;

  tsn_reorder_buffer_unit #(
    .WINDOW(WIN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predicted association state
  logic [31:0]            last_dlv;
  logic [WIN-1:0]         slot_vld;
  logic [PayloadBits-1:0] slot_pay [WIN];

  in_item_t  chunks_to_send [$];
  out_item_t results_due [$];

  int          gen_cnt;
  int          chunks_taken;
  int          results_seen;
  int          err_cnt;
  int          cfg_writes;
  int          max_run;
  int          sts_seen [4];
  int          gap_cnt;
  int          stall_cnt;
  int          hold_cnt;
  int          idle_cycles;
  bit          long_hold_done;
  bit          quiet;
  logic [15:0] cyc = '0;

  function automatic void advance_window();
    slot_vld = slot_vld >> 1;
    for (int k = 0; k < WIN - 1; k++) slot_pay[k] = slot_pay[k+1];
    slot_pay[WIN-1] = '0;
  endfunction

  function automatic void load_peer_tsn(logic [31:0] v);
    last_dlv = v - 32'd1;
    slot_vld = '0;
    foreach (slot_pay[k]) slot_pay[k] = '0;
  endfunction

  task automatic predict_delivery(in_item_t chunk);
    logic [31:0] ofs;
    out_item_t   res;
    out_item_t   run [$];
    ofs = chunk.chunk_tsn - (last_dlv + 32'd1);
    res.status      = StsDelivered;
    res.out_tsn     = chunk.chunk_tsn;
    res.out_payload = '0;
    res.last_of_run = 1'b0;
    if (ofs == 32'd0) begin
      res.out_payload = chunk.payload_handle;
      run.insert(run.size(), res);
      last_dlv = chunk.chunk_tsn;
      // slot 0 holds the next number until the closing shift
      while (slot_vld[0]) begin
        last_dlv        = last_dlv + 32'd1;
        res.out_tsn     = last_dlv;
        res.out_payload = slot_pay[0];
        run.insert(run.size(), res);
        advance_window();
      end
      advance_window();
    end else if (ofs[31]) begin
      res.status = StsOld;
    end else if (ofs > WIN) begin
      res.status = StsBeyond;
    end else begin
      slot_vld[ofs-1] = 1'b1;
      slot_pay[ofs-1] = chunk.payload_handle;
      res.status      = StsBuffered;
    end
    if (ofs != 32'd0) run.insert(run.size(), res);
    res = run.pop_back();
    res.last_of_run = 1'b1;
    run.insert(run.size(), res);
    if (run.size() > max_run) max_run = run.size();
    foreach (run[i]) results_due.insert(results_due.size(), run[i]);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result at %0t: sts %0d tsn %h pay %h last %b", $time,
                 got.status, got.out_tsn, got.out_payload, got.last_of_run);
    end else begin
      want = results_due.pop_front();
      if (got.status !== want.status || got.out_tsn !== want.out_tsn ||
          got.out_payload !== want.out_payload || got.last_of_run !== want.last_of_run) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display({"mismatch at %0t: want sts %0d tsn %h pay %h last %b, ",
                    "got sts %0d tsn %h pay %h last %b"},
                   $time, want.status, want.out_tsn, want.out_payload, want.last_of_run,
                   got.status, got.out_tsn, got.out_payload, got.last_of_run);
      end
    end
  endtask

  function automatic logic [PayloadBits-1:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PayloadBits'($urandom);
    endcase
  endfunction

  task automatic queue_chunk(logic [31:0] t, logic [PayloadBits-1:0] p);
    in_item_t c;
    c.chunk_tsn      = t;
    c.payload_handle = p;
    chunks_to_send.insert(chunks_to_send.size(), c);
    gen_cnt++;
  endtask

  // old, beyond and half-range numbers relative to the generator's next number
  task automatic queue_noise(logic [31:0] base);
    logic [31:0] t;
    case ($urandom_range(0, 5))
      0:       t = base - $urandom_range(1, 40);
      1:       t = base + 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
      2:       t = base + 32'd33 + $urandom_range(0, 64);
      3:       t = base + $urandom_range(33, 32'h7FFF_FFFF);
      4:       t = base + ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      default: t = $urandom;
    endcase
    queue_chunk(t, pick_payload());
  endtask

  // a gap-free run of numbers in shuffled order, now and then with repeats,
  // noise in between, or one number held back until the end
  task automatic queue_run(inout logic [31:0] base, input int len, input bit head_last);
    logic [31:0] seq [$];
    logic [31:0] tmp;
    logic [31:0] held;
    int          i;
    int          j;
    bit          defer;
    for (i = 0; i < len; i++) seq.insert(seq.size(), base + i);
    for (i = len - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      tmp    = seq[i];
      seq[i] = seq[j];
      seq[j] = tmp;
    end
    if (head_last) begin
      for (i = 0; i < seq.size(); i++)
        if (seq[i] == base) j = i;
      seq.delete(j);
      seq.insert(seq.size(), base);
    end
    defer = (len > 1) && !head_last && ($urandom_range(0, 4) == 0);
    if (defer) held = seq.pop_front();
    foreach (seq[k]) begin
      if ($urandom_range(0, 7) == 0) queue_noise(base);
      queue_chunk(seq[k], pick_payload());
      if ($urandom_range(0, 9) == 0) queue_chunk(seq[k], pick_payload());
    end
    if (defer) begin
      repeat ($urandom_range(1, 3)) queue_noise(base);
      queue_chunk(held, pick_payload());
    end
    base = base + len;
  endtask

  task automatic wait_drained();
    while (chunks_to_send.size() != 0 || push || results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_peer_tsn(logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    load_peer_tsn(v);
    cfg_writes++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_chunks
    if (!rst_ni) begin
      push    <= 1'b0;
      item_i  <= '0;
      gap_cnt <= 0;
    end else begin
      if (push && !full) begin
        predict_delivery(chunks_to_send.pop_front());
        chunks_taken++;
      end
      // a refused beat stays on the port untouched
      if (!(push && full)) begin
        if (gap_cnt != 0) begin
          push    <= 1'b0;
          gap_cnt <= gap_cnt - 1;
        end else if (chunks_to_send.size() != 0 && !quiet && cyc[7:6] != 2'b11 &&
                     $urandom_range(0, 99) < 12) begin
          push    <= 1'b0;
          gap_cnt <= $urandom_range(0, 5);
        end else if (chunks_to_send.size() != 0) begin
          push   <= 1'b1;
          item_i <= chunks_to_send[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : take_results
    if (!rst_ni) begin
      pop       <= 1'b0;
      stall_cnt <= 0;
      hold_cnt  <= 0;
    end else begin
      if (pop && !empty) begin
        check_result(result_o);
        sts_seen[result_o.status]++;
        results_seen++;
      end
      // one long hold-off so the intake backs up while chunks keep coming
      if (!long_hold_done && results_seen >= 80) begin
        long_hold_done = 1'b1;
        hold_cnt <= LONG_HOLD - 1;
        pop      <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        pop      <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
        pop       <= 1'b0;
      end else if (!quiet && cyc[8:7] != 2'b00 && $urandom_range(0, 99) < 15) begin
        stall_cnt <= $urandom_range(0, 5);
        pop       <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 16'd1;
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tsn_reorder_buffer_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_phases
    logic [31:0] base;
    logic [31:0] peer_vals [5];
    int          start;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    load_peer_tsn(32'd0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // after reset the first expected number is 0
    queue_chunk(32'd0, 16'hFFFF);
    queue_chunk(32'd2, 16'h0000);
    queue_chunk(32'd33, 16'hAAAA);        // far edge of the window
    queue_chunk(32'd34, 16'h5555);        // one past it
    queue_chunk(32'd0, 16'h1111);         // duplicate of a delivered chunk
    queue_chunk(32'h8000_0001, 16'h2222); // exactly half the number space ahead
    queue_chunk(32'h8000_0000, 16'h3333); // just under half
    queue_chunk(32'hFFFF_FFFF, 16'hFFFF);
    queue_chunk(32'd2, 16'h5555);         // overwrite of a buffered entry
    queue_chunk(32'd1, 16'h1234);
    queue_chunk(32'd4, 16'h0001);
    queue_chunk(32'd3, 16'h0002);
    queue_chunk(32'd37, 16'h8001);
    queue_chunk(32'd38, 16'h7FFE);
    queue_chunk(32'h5A5A_A5A5, 16'hC3C3);
    wait_drained();

    peer_vals[0] = 32'hFFFF_FFF0;
    peer_vals[1] = 32'h7FFF_FFF8;
    peer_vals[2] = $urandom;
    peer_vals[3] = 32'hFFFF_FFFF;
    peer_vals[4] = 32'h0000_0000;
    for (int p = 0; p < 5; p++) begin
      if (p == 4) quiet = 1'b1;
      write_peer_tsn(peer_vals[p]);
      base  = peer_vals[p];
      start = gen_cnt;
      // fill the whole window behind a missing head, then release it
      if (p == 0) queue_run(base, WIN + 1, 1'b1);
      while (gen_cnt - start < PHASE_ITEMS) begin
        case ($urandom_range(0, 15))
          0:       queue_noise(base);
          1:       queue_run(base, WIN + 1, 1'b1);
          2, 3, 4: queue_run(base, $urandom_range(9, WIN), 1'b0);
          default: queue_run(base, $urandom_range(1, 8), $urandom_range(0, 3) == 0);
        endcase
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d chunks, %0d results over %0d peer tsn loads, longest run %0d beats",
             chunks_taken, results_seen, cfg_writes, max_run);
    $display("delivered %0d, buffered %0d, old %0d, beyond window %0d",
             sts_seen[StsDelivered], sts_seen[StsBuffered], sts_seen[StsOld],
             sts_seen[StsBeyond]);
    if (err_cnt == 0 && results_due.size() == 0) begin
      $display("tsn_reorder_buffer_unit regression: pass");
    end else begin
      $display("%0d failures, %0d results still due", err_cnt, results_due.size());
      $display("tsn_reorder_buffer_unit regression: fail");
    end
    $finish;
  end

endmodule
